// ===== rtl/core/hsv_to_rgb_pixel_converter_defines.svh =====
// Assertion macros for the HSV to RGB converter RTL, used by its queue.
`ifndef HSV_TO_RGB_PIXEL_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked on clk with arst_n low disabling the check.
`define HSVC_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// Next-cycle implication, checked on clk with arst_n low disabling the check.
`define HSVC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`endif

// ===== rtl/core/hsvc_pkg.sv =====
// Shared types, constants and helper functions for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsvc_pkg;

	localparam int unsigned SECTOR_SPAN = 255;
	localparam int unsigned HUE_CIRCLE  = 6 * SECTOR_SPAN;
	// floor(2^16 / 1530); the quotient estimate is at most one short.
	localparam int unsigned HUE_RECIP   = 65536 / HUE_CIRCLE;

	typedef enum logic [2:0] {
		SEC_RED_RISE_GREEN = 3'd0,
		SEC_GREEN_FALL_RED = 3'd1,
		SEC_GREEN_RISE_BLUE = 3'd2,
		SEC_BLUE_FALL_GREEN = 3'd3,
		SEC_BLUE_RISE_RED = 3'd4,
		SEC_RED_FALL_BLUE = 3'd5
	} sector_t;

	// One classified pixel, handed from the front end to the back end.
	typedef struct packed {
		sector_t     sector;
		logic [7:0]  c;
		logic [7:0]  sat;
		logic [7:0]  val;
	} task_t;

	// Start of a sector on the reduced hue scale.
	function automatic logic [10:0] sector_base(input sector_t sec);
		logic [10:0] base;
		unique case (sec)
			SEC_RED_RISE_GREEN:  base = 11'd0;
			SEC_GREEN_FALL_RED:  base = 11'd255;
			SEC_GREEN_RISE_BLUE: base = 11'd510;
			SEC_BLUE_FALL_GREEN: base = 11'd765;
			SEC_BLUE_RISE_RED:   base = 11'd1020;
			SEC_RED_FALL_BLUE:   base = 11'd1275;
			default:             base = 11'd0;
		endcase
		return base;
	endfunction

	// Truncating division by 255, exact for every operand up to 65279.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hsvc_front.sv =====
// Front end: takes pixels, reduces the hue and classifies it into sector and position.
`timescale 1ns / 1ps
`default_nettype none

module hsvc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic [15:0]     hue_in,
	input  wire logic [7:0]      sat_in,
	input  wire logic [7:0]      val_in,
	output logic                 task_valid,
	input  wire logic            task_ready,
	output hsvc_pkg::task_t      task_word
);

	logic            v_s1, v_s2, v_s3;
	logic            en_s1, en_s2, en_s3;

	logic [15:0]     hue_s1;
	logic [5:0]      quo_s1;
	logic [7:0]      sat_s1, sat_s2, sat_s3;
	logic [7:0]      val_s1, val_s2, val_s3;
	logic [10:0]     hred_s2;
	hsvc_pkg::sector_t sector_s3;
	logic [7:0]      c_s3;

	logic [21:0]     quo_prod;
	logic [15:0]     quo_mul;
	logic [15:0]     rem_raw;
	logic [15:0]     rem_fix;
	hsvc_pkg::sector_t sector_d;
	logic [10:0]     pos_wide;
	logic [7:0]      pos_d;

	assign en_s3 = !v_s3 || task_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign full  = !en_s1;

	assign quo_prod = hue_in * 22'(hsvc_pkg::HUE_RECIP);
	assign quo_mul  = {10'd0, quo_s1} * 16'(hsvc_pkg::HUE_CIRCLE);
	assign rem_raw  = hue_s1 - quo_mul;
	assign rem_fix  = (rem_raw >= 16'(hsvc_pkg::HUE_CIRCLE)) ?
		rem_raw - 16'(hsvc_pkg::HUE_CIRCLE) : rem_raw;

	always_comb begin
		if (hred_s2 >= 11'd1275) begin
			sector_d = hsvc_pkg::SEC_RED_FALL_BLUE;
		end else if (hred_s2 >= 11'd1020) begin
			sector_d = hsvc_pkg::SEC_BLUE_RISE_RED;
		end else if (hred_s2 >= 11'd765) begin
			sector_d = hsvc_pkg::SEC_BLUE_FALL_GREEN;
		end else if (hred_s2 >= 11'd510) begin
			sector_d = hsvc_pkg::SEC_GREEN_RISE_BLUE;
		end else if (hred_s2 >= 11'd255) begin
			sector_d = hsvc_pkg::SEC_GREEN_FALL_RED;
		end else begin
			sector_d = hsvc_pkg::SEC_RED_RISE_GREEN;
		end
	end

	assign pos_wide = hred_s2 - hsvc_pkg::sector_base(sector_d);
	// In odd sectors the rising channel runs the other way.
	assign pos_d    = sector_d[0] ? 8'd255 - pos_wide[7:0] : pos_wide[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= push;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			hue_s1 <= hue_in;
			quo_s1 <= quo_prod[21:16];
			sat_s1 <= sat_in;
			val_s1 <= val_in;
		end
		if (en_s2) begin
			hred_s2 <= rem_fix[10:0];
			sat_s2  <= sat_s1;
			val_s2  <= val_s1;
		end
		if (en_s3) begin
			sector_s3 <= sector_d;
			c_s3      <= pos_d;
			sat_s3    <= sat_s2;
			val_s3    <= val_s2;
		end
	end

	assign task_valid       = v_s3;
	assign task_word.sector = sector_s3;
	assign task_word.c      = c_s3;
	assign task_word.sat    = sat_s3;
	assign task_word.val    = val_s3;

endmodule

`default_nettype wire

// ===== rtl/core/hsvc_queue.sv =====
// Short register queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_pixel_converter_defines.svh"

module hsvc_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hsvc_pkg::task_t  wdata,
	output logic                  full,
	input  wire logic             pop,
	output hsvc_pkg::task_t       rdata,
	output logic                  empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	hsvc_pkg::task_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	`HSVC_ASSERT_IMPLIES(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
	`HSVC_ASSERT_IMPLIES(a_empty_ptrs, count_q == '0, wr_ptr_q == rd_ptr_q)
	`HSVC_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

// ===== rtl/core/hsvc_back.sv =====
// Back end: forms the three channels of a classified pixel and holds the result word.
`timescale 1ns / 1ps
`default_nettype none

module hsvc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             task_valid,
	output logic                  task_ready,
	input  wire hsvc_pkg::task_t  task_word,
	output logic                  empty,
	input  wire logic             pop,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue
);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              en_s1, en_s2, en_s3, en_s4;

	hsvc_pkg::sector_t sector_s1, sector_s2, sector_s3;
	logic [7:0]        c_s1, val_s1, val_s2, val_s3;
	logic [15:0]       mprod_s1, lprod_s1;
	logic [7:0]        lvl_s2, low_s2, low_s3;
	logic [15:0]       midprod_s3;
	logic [7:0]        red_s4, green_s4, blue_s4;

	logic [7:0]        inv_sat;
	logic [7:0]        mid_d;
	logic [7:0]        red_d, green_d, blue_d;

	assign en_s4      = !v_s4 || pop;
	assign en_s3      = !v_s3 || en_s4;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign task_ready = en_s1;

	assign inv_sat = 8'd255 - task_word.sat;
	assign mid_d   = hsvc_pkg::div255(midprod_s3);

	always_comb begin
		unique case (sector_s3)
			hsvc_pkg::SEC_RED_RISE_GREEN: begin
				red_d = val_s3; green_d = mid_d; blue_d = low_s3;
			end
			hsvc_pkg::SEC_GREEN_FALL_RED: begin
				red_d = mid_d; green_d = val_s3; blue_d = low_s3;
			end
			hsvc_pkg::SEC_GREEN_RISE_BLUE: begin
				red_d = low_s3; green_d = val_s3; blue_d = mid_d;
			end
			hsvc_pkg::SEC_BLUE_FALL_GREEN: begin
				red_d = low_s3; green_d = mid_d; blue_d = val_s3;
			end
			hsvc_pkg::SEC_BLUE_RISE_RED: begin
				red_d = mid_d; green_d = low_s3; blue_d = val_s3;
			end
			default: begin
				red_d = val_s3; green_d = low_s3; blue_d = mid_d;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= task_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sector_s1 <= task_word.sector;
			c_s1      <= task_word.c;
			val_s1    <= task_word.val;
			mprod_s1  <= {8'd0, inv_sat} * {8'd0, 8'd255 - task_word.c};
			lprod_s1  <= {8'd0, inv_sat} * {8'd0, task_word.val};
		end
		if (en_s2) begin
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			// The sum stays within 255 for every c and saturation.
			lvl_s2    <= c_s1 + hsvc_pkg::div255(mprod_s1);
			low_s2    <= hsvc_pkg::div255(lprod_s1);
		end
		if (en_s3) begin
			sector_s3  <= sector_s2;
			val_s3     <= val_s2;
			low_s3     <= low_s2;
			midprod_s3 <= {8'd0, lvl_s2} * {8'd0, val_s2};
		end
		if (en_s4) begin
			red_s4   <= red_d;
			green_s4 <= green_d;
			blue_s4  <= blue_d;
		end
	end

	assign empty = !v_s4;
	assign red   = red_s4;
	assign green = green_s4;
	assign blue  = blue_s4;

endmodule

`default_nettype wire

// ===== rtl/core/hsv_to_rgb_pixel_converter.sv =====
// Top level of the HSV to RGB pixel converter.
//
// Input channel: a pixel word (hue_in, sat_in, val_in) is taken at a rising
// edge of clk where push is high and full is low. Result channel: while empty
// is low the oldest result word sits on red_out, green_out, blue_out and
// packed_rgb, and it is taken at an edge where pop is high.
// A word accepted at one edge passes through three front stages that reduce the
// hue modulo 1530 and find sector and position, then through the queue, and
// then through four back stages that do the two multiply and divide-by-255
// passes and the channel selection. One word is accepted and one delivered
// every cycle while the result side does not stall; every stage takes a new
// word whenever the stage after it moves, so nothing in the path is iterative.
// When pop stays low the back pipeline fills, the queue of QUEUE_DEPTH words
// fills behind it, and full rises once the front stages are occupied as well;
// no word is lost or repeated.
// Reset (arst_n low, asynchronous) empties every stage and the queue, so
// empty is high and full is low right after reset; the block keeps no state
// between pixels.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_pixel_converter #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] hue_in,
	input  wire logic [7:0]  sat_in,
	input  wire logic [7:0]  val_in,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic [23:0]      packed_rgb
);

	// Front end to queue.
	logic            fe_valid;
	logic            fe_ready;
	hsvc_pkg::task_t fe_word;

	// Queue to back end.
	logic            q_full;
	logic            q_empty;
	logic            be_ready;
	hsvc_pkg::task_t q_word;

	hsvc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.hue_in     (hue_in),
		.sat_in     (sat_in),
		.val_in     (val_in),
		.task_valid (fe_valid),
		.task_ready (fe_ready),
		.task_word  (fe_word)
	);

	assign fe_ready = !q_full;

	hsvc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_valid),
		.wdata  (fe_word),
		.full   (q_full),
		.pop    (be_ready),
		.rdata  (q_word),
		.empty  (q_empty)
	);

	hsvc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_valid (!q_empty),
		.task_ready (be_ready),
		.task_word  (q_word),
		.empty      (empty),
		.pop        (pop),
		.red        (red_out),
		.green      (green_out),
		.blue       (blue_out)
	);

	// Packed word: red in the top byte, blue in the bottom byte.
	assign packed_rgb = {red_out, green_out, blue_out};

endmodule

`default_nettype wire
